// File: sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, sizes and codes of the 3x3 morphology filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W  = 8;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int DIM_W  = $clog2(MAX_WIDTH) + 1;
   localparam int HDIM_W = $clog2(MAX_HEIGHT) + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT) + 2;
   localparam int LAT_W  = $clog2(2 * MAX_WIDTH + 3);
   localparam int TICK_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 4 * MAX_WIDTH + 5);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OPERATION    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BINARY_MODE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ELEMENT_MASK = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_ROW   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_COL   = 3'd6;

   localparam logic [1:0] OP_ERODE  = 2'd0;
   localparam logic [1:0] OP_DILATE = 2'd1;
   localparam logic [1:0] OP_OPEN   = 2'd2;
   localparam logic [1:0] OP_CLOSE  = 2'd3;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [HDIM_W-1:0] height;
      logic [1:0]        anchor_row;
      logic [1:0]        anchor_col;
      logic [8:0]        mask;
      logic              binary;
      logic [LAT_W-1:0]  lat;
   } cell_cfg_type;

   typedef struct packed {
      logic             strobe;
      logic             in_frame;
      logic             restart;
      logic             last;
      logic [PIX_W-1:0] value;
   } tap_type;

endpackage

// File: sv/mf3_cell.sv
// ----------------------------------------------------------------------------
// mf3_cell
// One morphology pass: two line stores, 3x3 window and masked min/max.
// ----------------------------------------------------------------------------
module mf3_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     restart,
   input  logic                     push,
   input  logic [mf3_pkg::PIX_W-1:0] pixel,
   input  logic                     erode,
   input  mf3_pkg::cell_cfg_type    cfg,
   output mf3_pkg::tap_type         tap
);

   localparam int RS_W = mf3_pkg::ROW_W + 2;
   localparam int CS_W = mf3_pkg::COL_W + 2;

   logic [mf3_pkg::PIX_W-1:0] line1_mem [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0] line2_mem [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0] rd1_ff, rd2_ff;
   logic [mf3_pkg::PIX_W-1:0] win_ff [9];
   logic [mf3_pkg::PIX_W-1:0] win_in [9];

   logic [mf3_pkg::COL_W-1:0] col_ff, col_in, col_base;
   logic [mf3_pkg::LAT_W-1:0] wcnt_ff, wcnt_in, wcnt_base;
   logic [mf3_pkg::COL_W-1:0] kcol_ff, kcol_in, kcol_base;
   logic [mf3_pkg::ROW_W-1:0] krow_ff, krow_in, krow_base;
   logic [mf3_pkg::COL_W-1:0] okcol_ff, okcol_in;
   logic [mf3_pkg::ROW_W-1:0] okrow_ff, okrow_in;
   logic                      strobe_ff, strobe_in;
   logic                      rst_ff, rst_in;

   logic push_e, clear_e, warm;
   logic [mf3_pkg::DIM_W-1:0] w_last;
   logic [2:0] row_ok, col_ok;
   logic [RS_W-1:0] rsum;
   logic [CS_W-1:0] csum;
   logic [mf3_pkg::PIX_W-1:0] v, acc, pad;
   logic in_frame;

   assign push_e  = en && push;
   assign clear_e = en && restart;
   assign w_last  = cfg.width - mf3_pkg::DIM_W'(1);

   always_comb begin
      col_base  = clear_e ? '0 : col_ff;
      wcnt_base = clear_e ? '0 : wcnt_ff;
      kcol_base = clear_e ? '0 : kcol_ff;
      krow_base = clear_e ? '0 : krow_ff;
      warm      = (wcnt_base == cfg.lat);
      col_in    = col_base;
      wcnt_in   = wcnt_base;
      kcol_in   = kcol_base;
      krow_in   = krow_base;
      strobe_in = en ? 1'b0 : strobe_ff;
      rst_in    = en ? restart : rst_ff;
      okcol_in  = okcol_ff;
      okrow_in  = okrow_ff;
      for (int t = 0; t < 9; t++) begin
         win_in[t] = win_ff[t];
      end
      if (push_e) begin
         col_in = ({1'b0, col_base} == w_last) ? '0 : col_base + mf3_pkg::COL_W'(1);
         win_in[0] = pixel;
         win_in[3] = rd1_ff;
         win_in[6] = rd2_ff;
         for (int t = 0; t < 3; t++) begin
            win_in[t*3+1] = win_ff[t*3];
            win_in[t*3+2] = win_ff[t*3+1];
         end
         if (!warm) begin
            wcnt_in = wcnt_base + mf3_pkg::LAT_W'(1);
         end else begin
            strobe_in = 1'b1;
            okcol_in  = kcol_base;
            okrow_in  = krow_base;
            if ({1'b0, kcol_base} == w_last) begin
               kcol_in = '0;
               krow_in = krow_base + mf3_pkg::ROW_W'(1);
            end else begin
               kcol_in = kcol_base + mf3_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_e) begin
         line1_mem[col_base] <= pixel;
         line2_mem[col_base] <= rd1_ff;
      end
      if (push_e && col_base == col_in) begin
         rd1_ff <= pixel;
         rd2_ff <= rd1_ff;
      end else begin
         rd1_ff <= line1_mem[col_in];
         rd2_ff <= line2_mem[col_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         wcnt_ff   <= '0;
         kcol_ff   <= '0;
         krow_ff   <= '0;
         strobe_ff <= 1'b0;
         rst_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         wcnt_ff   <= wcnt_in;
         kcol_ff   <= kcol_in;
         krow_ff   <= krow_in;
         strobe_ff <= strobe_in;
         rst_ff    <= rst_in;
      end
      okcol_ff <= okcol_in;
      okrow_ff <= okrow_in;
      for (int t = 0; t < 9; t++) begin
         win_ff[t] <= win_in[t];
      end
   end

   // frame bounds of each kernel row and column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsum = {2'b00, okrow_ff} + RS_W'(i);
         row_ok[i] = (rsum >= RS_W'(cfg.anchor_row)) &&
                     (rsum < RS_W'(cfg.height) + RS_W'(cfg.anchor_row));
         csum = {2'b00, okcol_ff} + CS_W'(i);
         col_ok[i] = (csum >= CS_W'(cfg.anchor_col)) &&
                     (csum < CS_W'(cfg.width) + CS_W'(cfg.anchor_col));
      end
   end

   always_comb begin
      pad = (erode && !cfg.binary) ? mf3_pkg::PIX_FULL : '0;
      acc = erode ? mf3_pkg::PIX_FULL : '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            v = (row_ok[i] && col_ok[j]) ? win_ff[(2-i)*3+(2-j)] : pad;
            if (cfg.mask[i*3+j]) begin
               if (cfg.binary) begin
                  if (erode && v != mf3_pkg::PIX_FULL) acc = '0;
                  if (!erode && v == mf3_pkg::PIX_FULL) acc = mf3_pkg::PIX_FULL;
               end else begin
                  if (erode && v < acc) acc = v;
                  if (!erode && v > acc) acc = v;
               end
            end
         end
      end
   end

   assign in_frame     = (okrow_ff < mf3_pkg::ROW_W'(cfg.height));
   assign tap.strobe   = strobe_ff;
   assign tap.in_frame = in_frame;
   assign tap.restart  = rst_ff;
   assign tap.last     = (okrow_ff == mf3_pkg::ROW_W'(cfg.height) - mf3_pkg::ROW_W'(1)) &&
                         ({1'b0, okcol_ff} == w_last);
   assign tap.value    = in_frame ? acc : '0;

   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= cfg.lat) else $error("warm-up count past latency");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < cfg.width) else $error("line column out of row");
   a_first_out: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rst_ff |-> okrow_ff == '0 && okcol_ff == '0)
      else $error("restart output not at frame origin");
   a_out_col: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> {1'b0, okcol_ff} < cfg.width) else $error("output column out of row");

endmodule

// File: sv/morphology_filter_3x3.sv
// ----------------------------------------------------------------------------
// morphology_filter_3x3
// Streaming 3x3 erode/dilate/open/close over two chained pass cells.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while req_stall is low (output queue not full).
// Path: a result passes the pass cell's registers and then the output queue
//   (one pass), or both cells (open/close); the window delay is L or 2L items.
// Reset: synchronous; config registers to defaults, counters cleared. Line stores
//   are not cleared; their stale entries are always masked as out of frame.
module morphology_filter_3x3 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mf3_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mf3_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [mf3_pkg::DIM_W-1:0]  width_ff;
   logic [mf3_pkg::HDIM_W-1:0] height_ff;
   logic [1:0]                 op_ff;
   logic                       binary_ff;
   logic [8:0]                 mask_ff;
   logic [1:0]                 arow_ff, acol_ff;

   logic [mf3_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [1:0]                 count_ff;
   logic                       wr_ptr_ff, rd_ptr_ff;
   mf3_pkg::rsp_type           fifo_ff [2];

   mf3_pkg::cell_cfg_type      cfg;
   mf3_pkg::tap_type           tap1, tap2, fin;
   logic [mf3_pkg::DIM_W-1:0]  w;
   logic [mf3_pkg::HDIM_W-1:0] h;
   logic [1:0]                 ar, ac;
   logic [mf3_pkg::TICK_W-1:0] total, lat_x, frame_end;
   logic en, accept, drain, pix_restart, push1, csr_hit, two, res_push, pop;

   always_comb begin
      w = width_ff;
      if (width_ff == '0) w = mf3_pkg::DIM_W'(1);
      else if (width_ff > mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH))
         w = mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH);
      h = height_ff;
      if (height_ff == '0) h = mf3_pkg::HDIM_W'(1);
      else if (height_ff > mf3_pkg::HDIM_W'(mf3_pkg::MAX_HEIGHT))
         h = mf3_pkg::HDIM_W'(mf3_pkg::MAX_HEIGHT);
      ar = (arow_ff == 2'd3) ? 2'd2 : arow_ff;
      ac = (acol_ff == 2'd3) ? 2'd2 : acol_ff;
      case (ar)
         2'd0:    cfg.lat = mf3_pkg::LAT_W'({w, 1'b0});
         2'd1:    cfg.lat = mf3_pkg::LAT_W'(w);
         default: cfg.lat = '0;
      endcase
      cfg.lat        = cfg.lat + mf3_pkg::LAT_W'(2'd2 - ac);
      cfg.width      = w;
      cfg.height     = h;
      cfg.anchor_row = ar;
      cfg.anchor_col = ac;
      cfg.mask       = mask_ff;
      cfg.binary     = binary_ff;
   end

   assign two       = (op_ff == mf3_pkg::OP_OPEN) || (op_ff == mf3_pkg::OP_CLOSE);
   assign total     = mf3_pkg::TICK_W'(w) * mf3_pkg::TICK_W'(h);
   assign lat_x     = mf3_pkg::TICK_W'(cfg.lat);
   assign frame_end = total + (two ? (lat_x << 1) : lat_x);

   assign en          = (count_ff != 2'd2);
   assign req_stall   = !en;
   assign accept      = req_valid && en;
   assign drain       = req_data.action;
   assign pix_restart = !drain && (tick_ff >= total);
   assign push1       = accept && (!drain || (tick_ff >= total && tick_ff < frame_end));
   assign csr_hit     = csr_we && (csr_index <= mf3_pkg::REG_ANCHOR_COL);

   always_comb begin
      tick_in = tick_ff;
      if (csr_hit) tick_in = '0;
      else if (push1) tick_in = pix_restart ? mf3_pkg::TICK_W'(1)
                                            : tick_ff + mf3_pkg::TICK_W'(1);
   end

   mf3_cell u_pass1 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .restart (csr_hit || (accept && pix_restart)),
      .push    (push1),
      .pixel   (drain ? '0 : req_data.pixel_in),
      .erode   ((op_ff == mf3_pkg::OP_ERODE) || (op_ff == mf3_pkg::OP_OPEN)),
      .cfg     (cfg),
      .tap     (tap1)
   );

   mf3_cell u_pass2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .restart (csr_hit || tap1.restart),
      .push    (two && tap1.strobe),
      .pixel   (tap1.value),
      .erode   (op_ff == mf3_pkg::OP_CLOSE),
      .cfg     (cfg),
      .tap     (tap2)
   );

   assign fin      = two ? tap2 : tap1;
   assign res_push = en && fin.strobe && fin.in_frame;
   assign pop      = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::DIM_W'(640);
         height_ff <= mf3_pkg::HDIM_W'(480);
         op_ff     <= mf3_pkg::OP_ERODE;
         binary_ff <= 1'b0;
         mask_ff   <= 9'd186;
         arow_ff   <= 2'd1;
         acol_ff   <= 2'd1;
         tick_ff   <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mf3_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               mf3_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               mf3_pkg::REG_OPERATION:    op_ff     <= csr_wdata[1:0];
               mf3_pkg::REG_BINARY_MODE:  binary_ff <= csr_wdata[0];
               mf3_pkg::REG_ELEMENT_MASK: mask_ff   <= csr_wdata[8:0];
               mf3_pkg::REG_ANCHOR_ROW:   arow_ff   <= csr_wdata[1:0];
               mf3_pkg::REG_ANCHOR_COL:   acol_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
         tick_ff <= tick_in;
         if (res_push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, res_push} - {1'b0, pop};
      end
      if (res_push) begin
         fifo_ff[wr_ptr_ff].pixel_out  <= fin.value;
         fifo_ff[wr_ptr_ff].frame_last <= fin.last;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("output queue overflow");
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= frame_end) else $error("item count past frame end");
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> tick_ff == '0) else $error("register write did not restart frame");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 morphology filter. A table of directed
// items and register writes runs first, then randomized frames over many
// geometries, operations and masks. Every result is checked against an
// in-bench model of the two-pass window filter, or a table row's typed expectation.
// ----------------------------------------------------------------------------
module tb;

   localparam int HANG_LIMIT = 20000;

   typedef struct {
      bit                              is_cfg;
      logic [mf3_pkg::CSR_INDEX_W-1:0] idx;
      logic [mf3_pkg::CSR_DATA_W-1:0]  val;
      bit                              act;
      logic [7:0]                      pix;
      bit                              chk;
      logic [7:0]                      exp_pix;
      bit                              exp_last;
   } stim_row_type;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_valid = 0;
   logic                            req_stall;
   mf3_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 0;
   mf3_pkg::rsp_type                rsp_data;
   logic                            csr_we = 0;
   logic [mf3_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mf3_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   morphology_filter_3x3 uut (.*);

   always #5 clock = ~clock;

   // filter model state
   int         m_width, m_height, m_op, m_bin, m_mask, m_arow, m_acol;
   logic [7:0] line_a [2048];
   logic [7:0] line_b [2048];
   logic [7:0] win_a [9];
   logic [7:0] win_b [9];
   int         m_tick;

   mf3_pkg::rsp_type pending_pixels[$];
   int               errors = 0;
   int               idle_cnt = 0;
   bit               gaps_on = 1;
   stim_row_type     table_rows[$];
   int               pixel_items = 0;

   task automatic report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
   endtask

   function automatic void model_reset();
      m_width = 640; m_height = 480; m_op = mf3_pkg::OP_ERODE; m_bin = 0;
      m_mask = 186; m_arow = 1; m_acol = 1; m_tick = 0;
      foreach (win_a[i]) begin
         win_a[i] = 0;
         win_b[i] = 0;
      end
      foreach (line_a[i]) begin
         line_a[i] = 0;
         line_b[i] = 0;
      end
   endfunction

   function automatic void shift_in(bit second, int w, int idx, logic [7:0] x);
      int         span, s1, s2;
      logic [7:0] taps [3];
      span = 2 * w;
      s2 = idx % span;
      s1 = (idx + w) % span;
      taps[0] = x;
      taps[1] = second ? line_b[s1] : line_a[s1];
      taps[2] = second ? line_b[s2] : line_a[s2];
      if (second) line_b[s2] = x; else line_a[s2] = x;
      for (int t = 0; t < 3; t++) begin
         if (second) begin
            win_b[t*3+2] = win_b[t*3+1]; win_b[t*3+1] = win_b[t*3]; win_b[t*3] = taps[t];
         end else begin
            win_a[t*3+2] = win_a[t*3+1]; win_a[t*3+1] = win_a[t*3]; win_a[t*3] = taps[t];
         end
      end
   endfunction

   function automatic logic [7:0] window_value(bit second, bit ero, int k, int w, int h,
                                                int ar, int ac);
      int         ro, co, r, c;
      logic [7:0] acc, pad, v;
      ro = k / w; co = k % w;
      acc = ero ? mf3_pkg::PIX_FULL : 8'd0;
      pad = (ero && !m_bin) ? mf3_pkg::PIX_FULL : 8'd0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            if (m_mask[i*3+j]) begin
               r = ro + i - ar; c = co + j - ac;
               if (r < 0 || c < 0 || r >= h || c >= w) v = pad;
               else v = second ? win_b[(2-i)*3+(2-j)] : win_a[(2-i)*3+(2-j)];
               if (m_bin) begin
                  if (ero && v != mf3_pkg::PIX_FULL) acc = 0;
                  if (!ero && v == mf3_pkg::PIX_FULL) acc = mf3_pkg::PIX_FULL;
               end else begin
                  if (ero && v < acc) acc = v;
                  if (!ero && v > acc) acc = v;
               end
            end
         end
      return acc;
   endfunction

   function automatic int clamp(int v, int hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
   endfunction

   function automatic bit filter_step(bit act, logic [7:0] pix,
                                      output mf3_pkg::rsp_type r);
      int         w, h, ar, ac, lat, total, k1, k;
      bit         two, ero1, ero2, have;
      logic [7:0] v1, res;
      w = clamp(m_width, mf3_pkg::MAX_WIDTH); h = clamp(m_height, mf3_pkg::MAX_HEIGHT);
      ar = m_arow > 2 ? 2 : m_arow; ac = m_acol > 2 ? 2 : m_acol;
      lat = (2 - ar) * w + (2 - ac);
      total = w * h;
      two = m_op >= mf3_pkg::OP_OPEN;
      ero1 = (m_op == mf3_pkg::OP_ERODE || m_op == mf3_pkg::OP_OPEN);
      ero2 = (m_op == mf3_pkg::OP_CLOSE);
      have = 0; r = '0; k = 0; res = 0;
      if (act) begin
         if (m_tick < total || m_tick >= total + (two ? 2 * lat : lat)) return 0;
         pix = 0;
      end else if (m_tick >= total) m_tick = 0;
      shift_in(0, w, m_tick, pix);
      if (m_tick >= lat) begin
         k1 = m_tick - lat;
         v1 = 0;
         if (k1 < total) v1 = window_value(0, ero1, k1, w, h, ar, ac);
         if (!two) begin
            if (k1 < total) begin have = 1; k = k1; res = v1; end
         end else begin
            shift_in(1, w, k1, v1);
            if (k1 >= lat && k1 - lat < total) begin
               k = k1 - lat;
               res = window_value(1, ero2, k, w, h, ar, ac);
               have = 1;
            end
         end
      end
      m_tick++;
      r.pixel_out = res;
      r.frame_last = (k == total - 1);
      return have;
   endfunction

   task automatic settle();
      req_valid <= 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [mf3_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mf3_pkg::CSR_DATA_W-1:0] val);
      settle();
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         mf3_pkg::REG_IMAGE_WIDTH:  m_width = val;
         mf3_pkg::REG_IMAGE_HEIGHT: m_height = val;
         mf3_pkg::REG_OPERATION:    m_op = val[1:0];
         mf3_pkg::REG_BINARY_MODE:  m_bin = val[0];
         mf3_pkg::REG_ELEMENT_MASK: m_mask = val[8:0];
         mf3_pkg::REG_ANCHOR_ROW:   m_arow = val[1:0];
         mf3_pkg::REG_ANCHOR_COL:   m_acol = val[1:0];
         default: return;
      endcase
      m_tick = 0;
   endtask

   // chk: push the typed expectation instead of the predicted one
   task automatic send(bit act, logic [7:0] pix, bit chk = 0,
                       mf3_pkg::rsp_type typed = '0);
      mf3_pkg::rsp_type r;
      while (gaps_on && $urandom_range(99) < 23) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{action: act, pixel_in: pix};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!act) pixel_items++;
      if (filter_step(act, pix, r)) pending_pixels.push_back(chk ? typed : r);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= gaps_on && ($urandom_range(99) < 23);
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) begin
         if (pending_pixels.size() == 0) report("result with none expected");
         else begin
            if (rsp_data.pixel_out !== pending_pixels[0].pixel_out)
               report($sformatf("pixel_out %0d, want %0d", rsp_data.pixel_out,
                                pending_pixels[0].pixel_out));
            if (rsp_data.frame_last !== pending_pixels[0].frame_last)
               report($sformatf("frame_last %0d, want %0d", rsp_data.frame_last,
                                pending_pixels[0].frame_last));
            void'(pending_pixels.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= HANG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic add_cfg(logic [mf3_pkg::CSR_INDEX_W-1:0] idx,
                          logic [mf3_pkg::CSR_DATA_W-1:0] val);
      table_rows.push_back('{1, idx, val, 0, 0, 0, 0, 0});
   endtask

   task automatic add_px(bit act, logic [7:0] pix, bit chk = 0, logic [7:0] ep = 0,
                         bit el = 0);
      table_rows.push_back('{0, 0, 0, act, pix, chk, ep, el});
   endtask

   // one frame with random content, then its flush; sometimes broken
   task automatic run_frame(bit rough);
      int         w, h, ar, ac, lat, total, cut;
      logic [7:0] p;
      w = clamp(m_width, mf3_pkg::MAX_WIDTH); h = clamp(m_height, mf3_pkg::MAX_HEIGHT);
      ar = m_arow > 2 ? 2 : m_arow; ac = m_acol > 2 ? 2 : m_acol;
      lat = (2 - ar) * w + (2 - ac);
      if (m_op >= mf3_pkg::OP_OPEN) lat = 2 * lat;
      total = w * h;
      cut = (rough && $urandom_range(3) == 0) ? $urandom_range(total) : total;
      for (int i = 0; i < cut; i++) begin
         if (m_bin) p = $urandom_range(2) != 0 ? mf3_pkg::PIX_FULL : 8'($urandom_range(255));
         else p = 8'($urandom_range(255));
         send(0, p);
         if (rough && $urandom_range(15) == 0) send(1, 0);
      end
      if (rough && $urandom_range(4) == 0) cut = $urandom_range(lat);
      else cut = lat + (rough ? $urandom_range(2) : 0);
      for (int i = 0; i < cut; i++) send(1, 0);
   endtask

   initial begin
      stim_row_type row;
      model_reset();
      // single-pixel frames with anchor at the far corner: no delay
      add_cfg(mf3_pkg::REG_IMAGE_WIDTH, 1); add_cfg(mf3_pkg::REG_IMAGE_HEIGHT, 1);
      add_cfg(mf3_pkg::REG_ANCHOR_ROW, 2); add_cfg(mf3_pkg::REG_ANCHOR_COL, 2);
      add_cfg(mf3_pkg::REG_ELEMENT_MASK, 0);
      add_px(0, 8'd77, 1, 8'd255, 1);
      add_cfg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_DILATE);
      add_px(0, 8'd200, 1, 8'd0, 1);
      add_cfg(mf3_pkg::REG_ELEMENT_MASK, 9'h100);
      add_px(0, 8'd0, 1, 8'd0, 1);
      add_px(0, 8'd255, 1, 8'd255, 1);
      add_cfg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_ERODE);
      add_px(0, 8'd0, 1, 8'd0, 1);
      add_px(0, 8'd255, 1, 8'd255, 1);
      add_cfg(mf3_pkg::REG_BINARY_MODE, 1);
      add_px(0, 8'd254, 1, 8'd0, 1);
      add_px(0, 8'd255, 1, 8'd255, 1);
      add_cfg(mf3_pkg::REG_BINARY_MODE, 0);
      add_cfg(mf3_pkg::REG_ELEMENT_MASK, 9'h001);
      add_px(0, 8'd9, 1, 8'd255, 1);
      add_cfg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_DILATE);
      add_px(0, 8'd9, 1, 8'd0, 1);
      add_cfg(3'd7, 11'h7FF);
      // 3x3 open, full mask, anchor row 1 and column 3 (taken as 2)
      add_cfg(mf3_pkg::REG_IMAGE_WIDTH, 3); add_cfg(mf3_pkg::REG_IMAGE_HEIGHT, 3);
      add_cfg(mf3_pkg::REG_ANCHOR_ROW, 1); add_cfg(mf3_pkg::REG_ANCHOR_COL, 3);
      add_cfg(mf3_pkg::REG_ELEMENT_MASK, 9'h1FF);
      add_cfg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_OPEN);
      add_px(1, 0);
      for (int i = 0; i < 9; i++) add_px(0, 8'(i * 31));
      for (int i = 0; i < 7; i++) add_px(1, 0);

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         row = table_rows[i];
         if (row.is_cfg) write_reg(row.idx, row.val);
         else send(row.act, row.pix, row.chk, '{pixel_out: row.exp_pix,
                                                frame_last: row.exp_last});
      end

      // extremes of geometry: zero sizes, then sizes past the maximum
      write_reg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_ERODE);
      write_reg(mf3_pkg::REG_ANCHOR_ROW, 0); write_reg(mf3_pkg::REG_ANCHOR_COL, 0);
      write_reg(mf3_pkg::REG_IMAGE_WIDTH, 0); write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 0);
      run_frame(0);
      write_reg(mf3_pkg::REG_IMAGE_WIDTH, 11'h7FF); write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
      write_reg(mf3_pkg::REG_ANCHOR_ROW, 2); write_reg(mf3_pkg::REG_ANCHOR_COL, 2);
      write_reg(mf3_pkg::REG_OPERATION, mf3_pkg::OP_CLOSE);
      gaps_on = 0;
      for (int i = 0; i < 60; i++) send(0, 8'($urandom_range(255)));
      gaps_on = 1;

      while (pixel_items < 600) begin
         gaps_on = ($urandom_range(5) != 0);
         write_reg(mf3_pkg::REG_IMAGE_WIDTH,
                   11'($urandom_range(3) == 0 ? $urandom_range(40) : $urandom_range(1, 8)));
         write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 11'($urandom_range(1, 6)));
         write_reg(mf3_pkg::REG_OPERATION, 11'($urandom_range(3)));
         write_reg(mf3_pkg::REG_BINARY_MODE, 11'($urandom_range(1)));
         write_reg(mf3_pkg::REG_ELEMENT_MASK, 11'($urandom_range(511)));
         write_reg(mf3_pkg::REG_ANCHOR_ROW, 11'($urandom_range(3)));
         write_reg(mf3_pkg::REG_ANCHOR_COL, 11'($urandom_range(3)));
         repeat ($urandom_range(1, 3)) run_frame(1);
      end
      gaps_on = 1;

      settle();
      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
